[sv/sorted_leaf_segment_table_macros.svh]
// ----------------------------------------------------------------------------
// Sorted leaf segment table: assertion macros
// Shared property wrappers for the checker. Every property is clocked on the
// rising edge of clk and is switched off while reset is held.
// ----------------------------------------------------------------------------
`ifndef SORTED_LEAF_SEGMENT_TABLE_MACROS_SVH
`define SORTED_LEAF_SEGMENT_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted leaf segment table: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted leaf segment table: next-cycle check failed");

`endif

[sv/slst_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted leaf segment table package
// Sizes, operation and status codes, and the control bundle broadcast to the
// chain of element cells.
// ----------------------------------------------------------------------------
`default_nettype none

package slst_pkg;

  localparam int LEAF_SIZE    = 64;
  localparam int ELEMENT_BITS = 32;
  localparam int IDX_W        = $clog2(LEAF_SIZE);
  localparam int CNT_W        = $clog2(LEAF_SIZE + 1);
  localparam int GRP_SIZE     = 8;
  localparam int GRP_COUNT    = LEAF_SIZE / GRP_SIZE;
  localparam int GRP_W        = $clog2(GRP_COUNT);
  localparam int BIT_W        = $clog2(GRP_SIZE);

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [ELEMENT_BITS-1:0] elem_t;

  typedef enum logic [2:0] {
    OP_FIND   = 3'd0,
    OP_SET    = 3'd1,
    OP_INSERT = 3'd2,
    OP_APPEND = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE    = 1'b0,
    S_RESOLVE = 1'b1
  } state_t;

  typedef struct packed {
    logic  go;
    logic  apply;
    op_t   op;
    elem_t value;
    idx_t  pos;
    cnt_t  count;
  } cell_ctl_t;

endpackage

`default_nettype wire

[sv/slst_cell.sv]
// ----------------------------------------------------------------------------
// Sorted leaf segment table: element cell
// Holds one slot of the leaf. On a request it writes, takes its left or right
// neighbor's value, or holds, and it registers whether it matches the value.
// ----------------------------------------------------------------------------
`default_nettype none

module slst_cell (
  input  logic                clk,
  input  slst_pkg::idx_t      cell_idx,
  input  slst_pkg::cell_ctl_t ctl,
  input  slst_pkg::elem_t     left_val,
  input  slst_pkg::elem_t     right_val,
  output slst_pkg::elem_t     cell_val,
  output logic                match
);

  slst_pkg::elem_t data_r;
  slst_pkg::elem_t data_nxt;
  logic            match_r;
  logic            match_nxt;
  slst_pkg::cnt_t  idx_ext;
  slst_pkg::cnt_t  pos_ext;

  assign idx_ext = {1'b0, cell_idx};
  assign pos_ext = {1'b0, ctl.pos};

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    if (ctl.go) begin
      match_nxt = (data_r == ctl.value) && (idx_ext < ctl.count);
    end
    if (ctl.apply) begin
      case (ctl.op)
        slst_pkg::OP_SET: begin
          if (idx_ext == pos_ext) data_nxt = ctl.value;
        end
        slst_pkg::OP_INSERT: begin
          if (idx_ext == pos_ext) begin
            data_nxt = ctl.value;
          end else if ((idx_ext > pos_ext) && (idx_ext <= ctl.count)) begin
            data_nxt = left_val;
          end
        end
        slst_pkg::OP_APPEND: begin
          if (idx_ext == ctl.count) data_nxt = ctl.value;
        end
        slst_pkg::OP_REMOVE: begin
          if ((idx_ext >= pos_ext) && ((idx_ext + 1'b1) < ctl.count)) data_nxt = right_val;
        end
        default: begin
          data_nxt = data_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign cell_val = data_r;
  assign match    = match_r;

endmodule

`default_nettype wire

[sv/slst_prio.sv]
// ----------------------------------------------------------------------------
// Sorted leaf segment table: first-match encoder
// Finds the lowest set bit of the registered match row in two levels: first
// the lowest group with a hit, then the lowest bit inside that group.
// ----------------------------------------------------------------------------
`default_nettype none

module slst_prio (
  input  logic [slst_pkg::LEAF_SIZE-1:0] match_vec,
  output logic                           hit,
  output slst_pkg::idx_t                 hit_idx
);

  logic [slst_pkg::GRP_COUNT-1:0] grp_any;
  logic [slst_pkg::GRP_W-1:0]     grp_sel;
  logic [slst_pkg::GRP_SIZE-1:0]  grp_bits;
  logic [slst_pkg::BIT_W-1:0]     bit_sel;

  always_comb begin
    for (int g = 0; g < slst_pkg::GRP_COUNT; g++) begin
      grp_any[g] = |match_vec[g*slst_pkg::GRP_SIZE +: slst_pkg::GRP_SIZE];
    end
    grp_sel = '0;
    for (int g = slst_pkg::GRP_COUNT - 1; g >= 0; g--) begin
      if (grp_any[g]) grp_sel = slst_pkg::GRP_W'(g);
    end
    grp_bits = match_vec[grp_sel*slst_pkg::GRP_SIZE +: slst_pkg::GRP_SIZE];
    bit_sel  = '0;
    for (int b = slst_pkg::GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) bit_sel = slst_pkg::BIT_W'(b);
    end
  end

  assign hit     = |grp_any;
  assign hit_idx = {grp_sel, bit_sel};

endmodule

`default_nettype wire

[sv/sorted_leaf_segment_table.sv]
// ----------------------------------------------------------------------------
// Sorted leaf segment table
// One leaf of sorted elements held in a chain of cells, with find, set,
// insert, append and remove requests and one result per request.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_ready  operation, element_value, slot_position
//   out_     output     out_valid / out_ready status, found_index, fill_count
//
// At the accepting edge every cell compares and shifts at once; the block then
// moves to the resolve state, where the match row is encoded into the result
// register as soon as that register is free. No new request is taken until the
// last one has been loaded there. A stalled result holds in the output register;
// the block then takes one more request and waits in resolve until it frees.
// Reset empties the leaf at once; the element slots themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_leaf_segment_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_element_value,
  input  logic [5:0]  in_slot_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [6:0]  out_found_index,
  output logic [6:0]  out_fill_count
);

  slst_pkg::state_t  state_r;
  slst_pkg::state_t  state_nxt;
  slst_pkg::cnt_t    count_r;
  slst_pkg::cnt_t    count_nxt;
  slst_pkg::status_t st_r;
  slst_pkg::status_t st_nxt;
  logic              find_r;
  logic              find_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  slst_pkg::status_t out_status_r;
  slst_pkg::status_t out_status_nxt;
  logic [6:0]        out_found_r;
  logic [6:0]        out_found_nxt;
  logic [6:0]        out_fill_r;
  logic [6:0]        out_fill_nxt;

  logic                accept;
  logic                load;
  logic                leaf_full;
  slst_pkg::cnt_t      pos_ext;
  slst_pkg::status_t   req_status;
  logic                req_apply;
  slst_pkg::cnt_t      req_count;
  slst_pkg::cell_ctl_t ctl;
  slst_pkg::elem_t     cell_vals [slst_pkg::LEAF_SIZE];
  logic [slst_pkg::LEAF_SIZE-1:0] match_vec;
  logic                hit;
  slst_pkg::idx_t      hit_idx;

  assign in_ready  = (state_r == slst_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign leaf_full = (count_r == slst_pkg::cnt_t'(slst_pkg::LEAF_SIZE));
  assign pos_ext   = {1'b0, in_slot_position};

  always_comb begin
    req_status = slst_pkg::ST_OK;
    req_apply  = 1'b0;
    req_count  = count_r;
    case (in_operation)
      slst_pkg::OP_FIND: begin
        req_status = slst_pkg::ST_MISS;
      end
      slst_pkg::OP_SET: begin
        if (pos_ext >= count_r) req_status = slst_pkg::ST_RANGE;
        else req_apply = 1'b1;
      end
      slst_pkg::OP_INSERT: begin
        if (leaf_full) begin
          req_status = slst_pkg::ST_FULL;
        end else if (pos_ext > count_r) begin
          req_status = slst_pkg::ST_RANGE;
        end else begin
          req_apply = 1'b1;
          req_count = count_r + 1'b1;
        end
      end
      slst_pkg::OP_APPEND: begin
        if (leaf_full) begin
          req_status = slst_pkg::ST_FULL;
        end else begin
          req_apply = 1'b1;
          req_count = count_r + 1'b1;
        end
      end
      slst_pkg::OP_REMOVE: begin
        if (pos_ext >= count_r) begin
          req_status = slst_pkg::ST_RANGE;
        end else begin
          req_apply = 1'b1;
          req_count = count_r - 1'b1;
        end
      end
      default: begin
        req_status = slst_pkg::ST_RANGE;
      end
    endcase
  end

  assign ctl.go    = accept;
  assign ctl.apply = accept && req_apply;
  assign ctl.op    = slst_pkg::op_t'(in_operation);
  assign ctl.value = in_element_value;
  assign ctl.pos   = in_slot_position;
  assign ctl.count = count_r;

  for (genvar i = 0; i < slst_pkg::LEAF_SIZE; i++) begin : g_cell
    slst_pkg::elem_t left_val;
    slst_pkg::elem_t right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_left
      assign left_val = cell_vals[i-1];
    end
    if (i == slst_pkg::LEAF_SIZE - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_right
      assign right_val = cell_vals[i+1];
    end
    slst_cell u_cell (
      .clk       (clk),
      .cell_idx  (slst_pkg::idx_t'(i)),
      .ctl       (ctl),
      .left_val  (left_val),
      .right_val (right_val),
      .cell_val  (cell_vals[i]),
      .match     (match_vec[i])
    );
  end

  slst_prio u_prio (
    .match_vec (match_vec),
    .hit       (hit),
    .hit_idx   (hit_idx)
  );

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    count_nxt = count_r;
    st_nxt    = st_r;
    find_nxt  = find_r;
    case (state_r)
      slst_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = slst_pkg::S_RESOLVE;
          count_nxt = req_count;
          st_nxt    = req_status;
          find_nxt  = (in_operation == slst_pkg::OP_FIND);
        end
      end
      slst_pkg::S_RESOLVE: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = slst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = slst_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_fill_nxt   = out_fill_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_fill_nxt  = 7'(count_r);
      if (find_r && hit) begin
        out_status_nxt = slst_pkg::ST_OK;
        out_found_nxt  = 7'(hit_idx);
      end else if (find_r) begin
        out_status_nxt = slst_pkg::ST_MISS;
        out_found_nxt  = 7'(slst_pkg::LEAF_SIZE);
      end else begin
        out_status_nxt = st_r;
        out_found_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slst_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r         <= st_nxt;
    find_r       <= find_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_fill_count  = out_fill_r;

endmodule

`default_nettype wire

[sv/slst_chk.sv]
// ----------------------------------------------------------------------------
// Sorted leaf segment table: port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_leaf_segment_table_macros.svh"

module slst_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [6:0]  out_found_index,
  input logic [6:0]  out_fill_count
);

  `SLST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SLST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SLST_ASSERT_NOW(a_fill_bound, out_valid, out_fill_count <= 7'(slst_pkg::LEAF_SIZE))
  `SLST_ASSERT_NOW(a_miss_index, out_valid && (out_status == slst_pkg::ST_MISS),
    out_found_index == 7'(slst_pkg::LEAF_SIZE))
  `SLST_ASSERT_NOW(a_reject_index,
    out_valid && ((out_status == slst_pkg::ST_FULL) || (out_status == slst_pkg::ST_RANGE)),
    out_found_index == 7'd0)

endmodule

bind sorted_leaf_segment_table slst_chk u_slst_chk (.*);

`default_nettype wire
